/* hdl/rea_pkg.sv */
// Shared types, constants and a helper function for the ring element ALU.
package rea_pkg;

  // Fixed field widths of the request and result ports.
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned KIND_W     = 4;
  localparam int unsigned SHAMT_W    = 7;
  localparam int unsigned WID_W      = 7;
  localparam int unsigned SUM_W      = 8;
  localparam int unsigned CODE_W     = 2;
  localparam int unsigned LOW_W      = 6;
  localparam int unsigned HIGH_W     = 7;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned HALF_W     = DATA_W / 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH = 2'd0,
    REG_LOW   = 2'd1,
    REG_HIGH  = 2'd2
  } reg_idx_e;

  // Operation codes.
  typedef enum logic [KIND_W-1:0] {
    KIND_NOT  = 4'd0,
    KIND_NEG  = 4'd1,
    KIND_ADD  = 4'd2,
    KIND_SUB  = 4'd3,
    KIND_AND  = 4'd4,
    KIND_XOR  = 4'd5,
    KIND_MUL  = 4'd6,
    KIND_ASHR = 4'd7,
    KIND_SHR  = 4'd8,
    KIND_SHL  = 4'd9,
    KIND_REV  = 4'd10,
    KIND_MASK = 4'd11,
    KIND_EQ   = 4'd12,
    KIND_SEL  = 4'd13,
    KIND_MSB  = 4'd14,
    KIND_LSB  = 4'd15
  } kind_e;

  // Values derived from the configuration registers.
  typedef struct packed {
    logic [WID_W-1:0]  width;
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] range_mask;
    logic [SUM_W-1:0]  rev_sum;
  } cfg_t;

  // Ones in bit positions 0 to n-1.
  function automatic logic [DATA_W-1:0] low_ones(input logic [WID_W-1:0] n);
    logic [DATA_W-1:0] ones;
    if (n >= WID_W'(DATA_W)) begin
      ones = {DATA_W{1'b1}};
    end else begin
      ones = (DATA_W'(1) << n) - DATA_W'(1);
    end
    return ones;
  endfunction

endpackage

/* hdl/rea_cfg.sv */
// Configuration registers and the width, mask and range values derived from them.
module rea_cfg #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rea_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rea_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output rea_pkg::cfg_t                     cfg_o
);
  import rea_pkg::*;

  logic [CODE_W-1:0] width_code_q, width_code_d;
  logic [LOW_W-1:0]  range_low_q, range_low_d;
  logic [HIGH_W-1:0] range_high_q, range_high_d;

  logic [WID_W-1:0] width;
  logic [WID_W-1:0] lo;
  logic [WID_W-1:0] hi;

  // Register write decode; an index beyond the list changes nothing.
  always_comb begin
    width_code_d = width_code_q;
    range_low_d  = range_low_q;
    range_high_d = range_high_q;
    if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_WIDTH: width_code_d = cfg_data_i[CODE_W-1:0];
        REG_LOW:   range_low_d  = cfg_data_i[LOW_W-1:0];
        REG_HIGH:  range_high_d = cfg_data_i[HIGH_W-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_code_q <= CODE_W'(3);
      range_low_q  <= '0;
      range_high_q <= HIGH_W'(64);
    end else begin
      width_code_q <= width_code_d;
      range_low_q  <= range_low_d;
      range_high_q <= range_high_d;
    end
  end

  // Element width, limited to the widest element the block is built for.
  always_comb begin
    case (width_code_q)
      2'd0:    width = WID_W'(8);
      2'd1:    width = WID_W'(16);
      2'd2:    width = WID_W'(32);
      default: width = WID_W'(64);
    endcase
    if (width > WID_W'(MAX_WIDTH)) begin
      width = WID_W'(MAX_WIDTH);
    end
  end

  // Range bounds are clamped to the element width.
  assign lo = (WID_W'(range_low_q) > width) ? width : WID_W'(range_low_q);
  assign hi = (range_high_q > width) ? width : range_high_q;

  assign cfg_o.width      = width;
  assign cfg_o.mask       = low_ones(width);
  assign cfg_o.range_mask = low_ones(hi) & ~low_ones(lo);
  assign cfg_o.rev_sum    = SUM_W'(lo) + SUM_W'(hi);

endmodule

/* hdl/rea_logic.sv */
// Combinational logic for every operation except the multiply.
module rea_logic (
  input  rea_pkg::kind_e                     kind_i,
  input  logic [rea_pkg::DATA_W-1:0]         a_i,
  input  logic [rea_pkg::DATA_W-1:0]         b_i,
  input  logic [rea_pkg::SHAMT_W-1:0]        shamt_i,
  input  logic                               pick_b_i,
  input  rea_pkg::cfg_t                      cfg_i,
  output logic [rea_pkg::DATA_W-1:0]         result_o
);
  import rea_pkg::*;

  logic              sign;
  logic              too_far;
  logic [DATA_W-1:0] shr_val;
  logic [DATA_W-1:0] ashr_val;
  logic [DATA_W-1:0] shl_val;
  logic [DATA_W-1:0] rev_all;
  logic [DATA_W-1:0] rev_aligned;
  logic [DATA_W-1:0] rev_val;

  // Sign bit is the top bit of the element; operands arrive already masked.
  assign sign    = |(a_i & cfg_i.mask & ~(cfg_i.mask >> 1));
  assign too_far = SHAMT_W'(cfg_i.width) <= shamt_i;

  // Shifts; distances of the width or more give zero or the sign fill.
  assign shr_val  = too_far ? '0 : (a_i >> shamt_i);
  assign shl_val  = too_far ? '0 : (a_i << shamt_i);
  assign ashr_val = too_far ? (sign ? cfg_i.mask : '0)
                  : (sign ? ((a_i >> shamt_i) | ~(cfg_i.mask >> shamt_i))
                          : (a_i >> shamt_i));

  // Bit reverse of the range: reverse the whole word, then align the range.
  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      rev_all[i] = a_i[DATA_W-1-i];
    end
    if (cfg_i.rev_sum <= SUM_W'(DATA_W)) begin
      rev_aligned = rev_all >> (SUM_W'(DATA_W) - cfg_i.rev_sum);
    end else begin
      rev_aligned = rev_all << (cfg_i.rev_sum - SUM_W'(DATA_W));
    end
  end

  assign rev_val = (a_i & ~cfg_i.range_mask) | (rev_aligned & cfg_i.range_mask);

  // Operation select; the caller truncates to the element width.
  always_comb begin
    case (kind_i)
      KIND_NOT:  result_o = ~a_i;
      KIND_NEG:  result_o = '0 - a_i;
      KIND_ADD:  result_o = a_i + b_i;
      KIND_SUB:  result_o = a_i - b_i;
      KIND_AND:  result_o = a_i & b_i;
      KIND_XOR:  result_o = a_i ^ b_i;
      KIND_ASHR: result_o = ashr_val;
      KIND_SHR:  result_o = shr_val;
      KIND_SHL:  result_o = shl_val;
      KIND_REV:  result_o = rev_val;
      KIND_MASK: result_o = a_i & cfg_i.range_mask;
      KIND_EQ:   result_o = DATA_W'(a_i == b_i);
      KIND_SEL:  result_o = pick_b_i ? b_i : a_i;
      KIND_MSB:  result_o = DATA_W'(sign);
      KIND_LSB:  result_o = DATA_W'(a_i[0]);
      default:   result_o = '0;
    endcase
  end

endmodule

/* hdl/rea_mul.sv */
// Low half of a full-width product, built from registered half-width partial products.
module rea_mul (
  input  logic                          clk_i,
  input  logic [rea_pkg::DATA_W-1:0]    a_i,
  input  logic [rea_pkg::DATA_W-1:0]    b_i,
  output logic [rea_pkg::DATA_W-1:0]    product_o
);
  import rea_pkg::*;

  logic [DATA_W-1:0] pp_low_q, pp_low_d;
  logic [HALF_W-1:0] pp_cross_a_q, pp_cross_a_d;
  logic [HALF_W-1:0] pp_cross_b_q, pp_cross_b_d;

  // Three half-width products; the high-by-high term falls outside the result.
  assign pp_low_d     = DATA_W'(a_i[HALF_W-1:0]) * DATA_W'(b_i[HALF_W-1:0]);
  assign pp_cross_a_d = HALF_W'(a_i[HALF_W-1:0] * b_i[DATA_W-1:HALF_W]);
  assign pp_cross_b_d = HALF_W'(a_i[DATA_W-1:HALF_W] * b_i[HALF_W-1:0]);

  always_ff @(posedge clk_i) begin
    pp_low_q     <= pp_low_d;
    pp_cross_a_q <= pp_cross_a_d;
    pp_cross_b_q <= pp_cross_b_d;
  end

  // Combine the partial products in the following stage.
  assign product_o = pp_low_q + {pp_cross_a_q + pp_cross_b_q, {HALF_W{1'b0}}};

endmodule

/* hdl/ring_element_alu.sv */
// Top level of the ring element ALU: request capture, operation stage and result stage.
//
//  Channel   Direction  Ports                                        Transfer
//  request   in         start, busy, kind_i, operand_a_i,
//                       operand_b_i, shift_amount_i, pick_b_i        start && !busy
//  result    out        done_o, result_o                             done_o, one cycle
//  config    in         cfg_we_i, cfg_idx_i, cfg_data_i              cfg_we_i
//
// One request is taken in every cycle; busy never rises.
// Each result is registered at request capture, then at the partial products and other
// operations, then at the combine and truncate stage.
// Reset clears the valid bits and sets 64-bit elements with the full bit range.
// The receiver cannot stall, so results leave in request order with no back-pressure.
module ring_element_alu #(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [rea_pkg::KIND_W-1:0]        kind_i,
  input  logic [rea_pkg::DATA_W-1:0]        operand_a_i,
  input  logic [rea_pkg::DATA_W-1:0]        operand_b_i,
  input  logic [rea_pkg::SHAMT_W-1:0]       shift_amount_i,
  input  logic                              pick_b_i,
  output logic                              done_o,
  output logic [rea_pkg::DATA_W-1:0]        result_o,
  input  logic                              cfg_we_i,
  input  logic [rea_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rea_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import rea_pkg::*;

  cfg_t cfg;

  logic              v1_q, v1_d;
  kind_e             kind1_q;
  logic [DATA_W-1:0] a1_q;
  logic [DATA_W-1:0] b1_q;
  logic [SHAMT_W-1:0] shamt1_q;
  logic              pick1_q;

  logic              v2_q;
  logic              is_mul2_q;
  logic [DATA_W-1:0] alu2_q, alu2_d;
  logic [DATA_W-1:0] product;

  logic              v3_q;
  logic [DATA_W-1:0] result_q, result_d;

  rea_cfg #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // The pipeline never stalls, so a request is always taken.
  assign busy = 1'b0;
  assign v1_d = start & ~busy;

  // Stage one: capture the request with operands reduced to the element width.
  always_ff @(posedge clk_i) begin
    kind1_q  <= kind_e'(kind_i);
    a1_q     <= operand_a_i & cfg.mask;
    b1_q     <= operand_b_i & cfg.mask;
    shamt1_q <= shift_amount_i;
    pick1_q  <= pick_b_i;
  end

  // Stage two: partial products and all other operations.
  rea_logic u_logic (
    .kind_i   (kind1_q),
    .a_i      (a1_q),
    .b_i      (b1_q),
    .shamt_i  (shamt1_q),
    .pick_b_i (pick1_q),
    .cfg_i    (cfg),
    .result_o (alu2_d)
  );

  rea_mul u_mul (
    .clk_i     (clk_i),
    .a_i       (a1_q),
    .b_i       (b1_q),
    .product_o (product)
  );

  always_ff @(posedge clk_i) begin
    is_mul2_q <= (kind1_q == KIND_MUL);
    alu2_q    <= alu2_d;
  end

  // Stage three: pick the result and truncate it to the element width.
  assign result_d = (is_mul2_q ? product : alu2_q) & cfg.mask;

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign done_o   = v3_q;
  assign result_o = result_q;

  // Every result strobe traces back through stage two and stage one to a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni) v1_q |-> $past(start))
    else $error("stage one valid without a request");
  assert property (@(posedge clk_i) disable iff (!rst_ni) v2_q |-> $past(v1_q))
    else $error("stage two valid without stage one");
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> $past(v2_q))
    else $error("result strobe without stage two");

endmodule

/* bench/tb_ring_element_alu.sv */
// Self-checking bench for ring_element_alu: directed and random requests across widths and ranges.
`timescale 1ns / 100ps

module tb_ring_element_alu;
  import rea_pkg::*;

  localparam int unsigned MAX_WIDTH   = 64;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned BATCH_ITEMS = 118;
  localparam int unsigned NUM_PHASES  = 12;
  localparam int unsigned GAP_PERCENT = 11;
  localparam int unsigned QUIET_PHASE = 5;
  // The register file has no fourth register; writes to this index must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    kind_e             kind;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [SHAMT_W-1:0] shamt;
    logic              pick;
  } ring_req_t;

  typedef struct {
    kind_e             kind;
    logic [DATA_W-1:0] value;
  } ring_exp_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [KIND_W-1:0]     kind_i;
  logic [DATA_W-1:0]     operand_a_i;
  logic [DATA_W-1:0]     operand_b_i;
  logic [SHAMT_W-1:0]    shift_amount_i;
  logic                  pick_b_i;
  logic                  done_o;
  logic [DATA_W-1:0]     result_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Bench copy of the configuration registers.
  logic [CODE_W-1:0] cfg_code;
  logic [LOW_W-1:0]  cfg_low;
  logic [HIGH_W-1:0] cfg_high;

  ring_req_t   req_backlog[$];
  ring_exp_t   awaited_results[$];
  ring_req_t   in_flight;
  ring_exp_t   oldest_result;
  logic        steady;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  // Settings for the fixed phases: width code, low bound data, high bound data.
  int unsigned phase_code[10] = '{3, 0, 1, 2, 3, 0, 2, 1, 3, 0};
  int unsigned phase_low[10]  = '{0, 0, 5, 31, 63, 9, 70, 0, 17, 3};
  int unsigned phase_high[10] = '{64, 127, 12, 31, 64, 100, 1, 16, 45, 7};

  ring_element_alu #(
    .MAX_WIDTH(MAX_WIDTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .operand_a_i   (operand_a_i),
    .operand_b_i   (operand_b_i),
    .shift_amount_i(shift_amount_i),
    .pick_b_i      (pick_b_i),
    .done_o        (done_o),
    .result_o      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Free-running clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Ones in bit positions 0 to n-1.
  function automatic logic [DATA_W-1:0] ones_below(input int unsigned n);
    if (n >= DATA_W) begin
      return {DATA_W{1'b1}};
    end
    return (DATA_W'(1) << n) - DATA_W'(1);
  endfunction

  function automatic int unsigned elem_bits();
    int unsigned w;
    w = 8 << cfg_code;
    if (w > MAX_WIDTH) begin
      w = MAX_WIDTH;
    end
    return w;
  endfunction

  // Computes the element result for one request under the current configuration.
  function automatic logic [DATA_W-1:0] ring_op_result(input ring_req_t rq);
    int unsigned       w;
    int unsigned       lo;
    int unsigned       hi;
    int unsigned       i;
    logic [DATA_W-1:0] m;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] r;
    logic [DATA_W-1:0] field;
    logic              neg;
    w     = elem_bits();
    m     = ones_below(w);
    a     = rq.a & m;
    b     = rq.b & m;
    neg   = a[w-1];
    lo    = (cfg_low > w) ? w : cfg_low;
    hi    = (cfg_high > w) ? w : cfg_high;
    r     = '0;
    field = '0;
    case (rq.kind)
      KIND_NOT: r = ~a;
      KIND_NEG: r = DATA_W'(0) - a;
      KIND_ADD: r = a + b;
      KIND_SUB: r = a - b;
      KIND_AND: r = a & b;
      KIND_XOR: r = a ^ b;
      KIND_MUL: r = a * b;
      KIND_ASHR: begin
        // Sign fill comes from bit w-1, not bit 63.
        if (rq.shamt >= w) begin
          r = neg ? m : DATA_W'(0);
        end else if (neg) begin
          r = (a >> rq.shamt) | ~(m >> rq.shamt);
        end else begin
          r = a >> rq.shamt;
        end
      end
      KIND_SHR: r = (rq.shamt >= w) ? DATA_W'(0) : (a >> rq.shamt);
      KIND_SHL: r = (rq.shamt >= w) ? DATA_W'(0) : (a << rq.shamt);
      KIND_REV: begin
        // An empty range leaves the operand untouched.
        if (lo < hi) begin
          for (i = lo; i < hi; i++) begin
            field[hi - 1 - i + lo] = a[i];
          end
          r = (a & ~(ones_below(hi) & ~ones_below(lo))) | field;
        end else begin
          r = a;
        end
      end
      KIND_MASK: r = (lo < hi) ? (a & ones_below(hi) & ~ones_below(lo)) : DATA_W'(0);
      KIND_EQ:   r = (a == b) ? DATA_W'(1) : DATA_W'(0);
      KIND_SEL:  r = rq.pick ? b : a;
      KIND_MSB:  r = {{(DATA_W-1){1'b0}}, neg};
      default:   r = {{(DATA_W-1){1'b0}}, a[0]};
    endcase
    return r & m;
  endfunction

  // Operand values biased towards the corners of the current width.
  function automatic logic [DATA_W-1:0] draw_operand();
    int unsigned       w;
    logic [DATA_W-1:0] v;
    logic [DATA_W-1:0] junk;
    w    = elem_bits();
    junk = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2:       v = DATA_W'(1);
      3:       v = DATA_W'(1) << (w - 1);
      4:       v = ones_below(w - 1);
      5:       v = DATA_W'($urandom_range(0, 15));
      default: v = junk;
    endcase
    // Half the time, put noise above the element width as well.
    if ($urandom_range(0, 1) == 1) begin
      v = (v & ones_below(w)) | (junk & ~ones_below(w));
    end
    return v;
  endfunction

  function automatic logic [SHAMT_W-1:0] draw_shift();
    int unsigned w;
    w = elem_bits();
    case ($urandom_range(0, 5))
      0:       return SHAMT_W'($urandom_range(0, 127));
      1:       return SHAMT_W'(w - 1);
      2:       return SHAMT_W'(w);
      3:       return '0;
      default: return SHAMT_W'($urandom_range(0, w + 1));
    endcase
  endfunction

  function automatic ring_req_t random_request();
    ring_req_t rq;
    rq.kind  = kind_e'($urandom_range(0, 15));
    rq.a     = draw_operand();
    rq.b     = draw_operand();
    rq.shamt = draw_shift();
    rq.pick  = 1'($urandom_range(0, 1));
    // Equality needs matching operands often enough to be meaningful.
    if (rq.kind == KIND_EQ && $urandom_range(0, 1) == 1) begin
      rq.b = rq.a;
    end
    return rq;
  endfunction

  task automatic queue_req(input kind_e k, input logic [DATA_W-1:0] a,
                           input logic [DATA_W-1:0] b, input int unsigned s,
                           input logic p);
    ring_req_t rq;
    rq.kind  = k;
    rq.a     = a;
    rq.b     = b;
    rq.shamt = SHAMT_W'(s);
    rq.pick  = p;
    req_backlog.push_back(rq);
  endtask

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Waits until every request has gone in and every result has come back.
  task automatic wait_drained();
    while (req_backlog.size() != 0 || start || awaited_results.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Called at a rising edge; the write lands at the next one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == REG_WIDTH) begin
      cfg_code = data[CODE_W-1:0];
    end else if (idx == REG_LOW) begin
      cfg_low = data[LOW_W-1:0];
    end else if (idx == REG_HIGH) begin
      cfg_high = data[HIGH_W-1:0];
    end
    @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned code, input int unsigned low,
                           input int unsigned high, input logic spare);
    write_reg(REG_WIDTH, {CFG_DATA_W'($urandom_range(0, 31)) << CODE_W} | CFG_DATA_W'(code));
    write_reg(REG_LOW, CFG_DATA_W'(low));
    write_reg(REG_HIGH, CFG_DATA_W'(high));
    if (spare) begin
      write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(0, 127)));
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_batch(input int unsigned n);
    repeat (n) begin
      req_backlog.push_back(random_request());
    end
  endtask

  // Request driver: holds a request until it is taken, with random gaps between requests.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        awaited_results.push_back('{kind: in_flight.kind, value: ring_op_result(in_flight)});
      end
      if (!start || !busy) begin
        if (req_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= GAP_PERCENT)) begin
          in_flight = req_backlog.pop_front();
          kind_i         <= in_flight.kind;
          operand_a_i    <= in_flight.a;
          operand_b_i    <= in_flight.b;
          shift_amount_i <= in_flight.shamt;
          pick_b_i       <= in_flight.pick;
          start          <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each strobed result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (awaited_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h", result_o));
      end else begin
        oldest_result = awaited_results.pop_front();
        if (result_o !== oldest_result.value) begin
          flag_mismatch($sformatf("%s: result %h, expected %h", oldest_result.kind.name(),
                                  result_o, oldest_result.value));
        end
      end
    end
  end

  // Watchdog on the overall run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sequence of phases: reset defaults first, then fixed and random settings.
  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    kind_i         = '0;
    operand_a_i    = '0;
    operand_b_i    = '0;
    shift_amount_i = '0;
    pick_b_i       = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    steady         = 1'b0;
    cfg_code       = 2'd3;
    cfg_low        = '0;
    cfg_high       = 7'd64;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed corners under the reset configuration.
    queue_req(KIND_NOT, '0, '0, 0, 1'b0);
    queue_req(KIND_NOT, '1, '0, 0, 1'b0);
    queue_req(KIND_NEG, '0, '0, 0, 1'b0);
    queue_req(KIND_NEG, 64'h8000_0000_0000_0000, '0, 0, 1'b0);
    queue_req(KIND_ADD, '1, 64'd1, 0, 1'b0);
    queue_req(KIND_SUB, '0, 64'd1, 0, 1'b0);
    queue_req(KIND_AND, '1, 64'hA5A5_5A5A_F00F_0FF0, 0, 1'b0);
    queue_req(KIND_XOR, '1, 64'h0123_4567_89AB_CDEF, 0, 1'b0);
    queue_req(KIND_MUL, '1, '1, 0, 1'b0);
    queue_req(KIND_MUL, 64'h1_0000_0000, 64'h1_0000_0000, 0, 1'b0);
    queue_req(KIND_ASHR, 64'h8000_0000_0000_0001, '0, 1, 1'b0);
    queue_req(KIND_ASHR, 64'h8000_0000_0000_0000, '0, 64, 1'b0);
    queue_req(KIND_ASHR, 64'hC000_0000_0000_0000, '0, 127, 1'b0);
    queue_req(KIND_ASHR, 64'h7FFF_FFFF_FFFF_FFFF, '0, 63, 1'b0);
    queue_req(KIND_SHR, '1, '0, 0, 1'b0);
    queue_req(KIND_SHR, '1, '0, 64, 1'b0);
    queue_req(KIND_SHL, '1, '0, 63, 1'b0);
    queue_req(KIND_SHL, '1, '0, 127, 1'b0);
    queue_req(KIND_REV, 64'h0123_4567_89AB_CDEF, '0, 0, 1'b0);
    queue_req(KIND_MASK, '1, '0, 0, 1'b0);
    queue_req(KIND_EQ, 64'hDEAD_BEEF_0000_0001, 64'hDEAD_BEEF_0000_0001, 0, 1'b0);
    queue_req(KIND_EQ, '0, 64'd1, 0, 1'b0);
    queue_req(KIND_SEL, 64'd5, 64'd9, 0, 1'b0);
    queue_req(KIND_SEL, 64'd5, 64'd9, 0, 1'b1);
    queue_req(KIND_MSB, 64'h8000_0000_0000_0000, '0, 0, 1'b0);
    queue_req(KIND_LSB, 64'd1, '0, 0, 1'b0);
    random_batch(BATCH_ITEMS);
    wait_drained();

    for (int unsigned ph = 1; ph < NUM_PHASES; ph++) begin
      if (ph < 10) begin
        configure(phase_code[ph], phase_low[ph], phase_high[ph], ph == 4);
      end else begin
        configure($urandom_range(0, 3), $urandom_range(0, 127), $urandom_range(0, 127), 1'b1);
      end
      steady = (ph == QUIET_PHASE);
      random_batch(BATCH_ITEMS);
      wait_drained();
    end

    // Allow for any stray result still travelling through the pipeline.
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
